>>> rtl/sse_pkg.sv
`timescale 1ns / 1ps

package sse_pkg;

	// Permutation geometry
	localparam int STATE_SIZE = 256;
	localparam int IDX_W      = $clog2(STATE_SIZE);
	localparam int HALF_SIZE  = STATE_SIZE / 2;
	localparam int NIB_W      = 4;

	// Shuffle sequencing: whip, crush, whip, crush, whip
	localparam int WHIP_N  = 2 * STATE_SIZE;
	localparam int CNT_W   = $clog2(WHIP_N);
	localparam int HALF_W  = $clog2(HALF_SIZE);
	localparam int PH_W    = 3;
	localparam int PH_LAST = 4;

	// Operation codes carried by an input item
	typedef enum logic [1:0] {
		OP_INIT   = 2'd0,
		OP_ABSORB = 2'd1,
		OP_STOP   = 2'd2,
		OP_DRIP   = 2'd3
	} op_t;

	// Request from the sequencer to the permutation store
	typedef struct packed {
		logic             clr;
		logic             we;
		logic [IDX_W-1:0] waddr;
		logic [IDX_W-1:0] wdata;
		logic [IDX_W-1:0] raddr;
	} perm_req_t;

endpackage

>>> rtl/sse_perm.sv
`timescale 1ns / 1ps

module sse_perm import sse_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  perm_req_t        req,
	output logic [IDX_W-1:0] rdata
);

	logic [IDX_W-1:0]      mem [STATE_SIZE];
	logic [STATE_SIZE-1:0] vld_q;
	logic [IDX_W-1:0]      rd_mem_q;
	logic [IDX_W-1:0]      rd_addr_q;
	logic                  rd_vld_q;

	// Write one entry, read one entry with registered data
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rd_mem_q  <= mem[req.raddr];
		rd_addr_q <= req.raddr;
	end

	// Track written entries; an unwritten entry reads as its own index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.clr) begin
				vld_q <= '0;
			end else if (req.we) begin
				vld_q[req.waddr] <= 1'b1;
			end
			rd_vld_q <= vld_q[req.raddr];
		end
	end

	assign rdata = rd_vld_q ? rd_mem_q : rd_addr_q;

endmodule

>>> rtl/spritz_sponge_engine_core.sv
`timescale 1ns / 1ps
// Initialize and a plain absorb stop finish in idle; absorb byte swaps two nibbles in;
// a drip runs one update and then the output chain. A shuffle whips three times and
// crushes twice. The permutation store has a single read port, so every update steps
// through states U0 to U4 and every nibble swap through states N0 to N3.
// One item is in work at a time; a finished byte waits in an output register.
// Reset gives the identity permutation, stride 1 and all other registers zero.

module spritz_sponge_engine_core import sse_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] operation,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] stream_byte
);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_U0, ST_U1, ST_U2, ST_U3, ST_U4,
		ST_C0, ST_C1, ST_C2, ST_C3,
		ST_N0, ST_N1, ST_N2, ST_N3,
		ST_O0, ST_O1, ST_O2, ST_O3,
		ST_OUT
	} st_t;

	st_t              state_q;
	op_t              op_q;
	logic [IDX_W-1:0] i_q, j_q, k_q, z_q, a_q, w_q, t_q;
	logic [7:0]       byte_q;
	logic             nib_hi_q;
	logic             shuf_q;
	logic [PH_W-1:0]  phase_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic [7:0]       stream_q;

	perm_req_t          req;
	logic [IDX_W-1:0]   rdata;
	logic [IDX_W-1:0]   add_a, add_b, add_sum;
	logic [NIB_W-1:0]   nib;
	logic [IDX_W-1:0]   nib_addr;
	logic [HALF_W-1:0]  crush_v;
	logic [IDX_W-1:0]   crush_lo, crush_hi;
	logic               accept;
	op_t                op_in;

	sse_perm u_perm (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (rdata)
	);

	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;
	assign stream_byte = stream_q;
	assign accept      = in_valid && in_ready;
	assign op_in       = op_t'(operation);

	// Derive swap addresses for nibbles and crush pairs
	assign nib      = nib_hi_q ? byte_q[7:4] : byte_q[3:0];
	assign nib_addr = IDX_W'(HALF_SIZE) + IDX_W'(nib);
	assign crush_v  = cnt_q[HALF_W-1:0];
	assign crush_lo = {1'b0, crush_v};
	assign crush_hi = ~{1'b0, crush_v};

	// Shared index adder; it drives the read address
	assign add_sum = add_a + add_b;

	// Issue reads and writes to the permutation store
	always_comb begin
		add_a     = '0;
		add_b     = '0;
		req.clr   = 1'b0;
		req.we    = 1'b0;
		req.waddr = '0;
		req.wdata = '0;
		case (state_q)
			ST_IDLE: req.clr = accept && (op_in == OP_INIT);
			ST_U0: begin
				add_a = i_q;
				add_b = w_q;
			end
			ST_U1: begin
				add_a = j_q;
				add_b = rdata;
			end
			ST_U2: begin
				add_a = k_q;
				add_b = rdata;
			end
			ST_U3: begin
				req.we    = 1'b1;
				req.waddr = i_q;
				req.wdata = rdata;
			end
			ST_U4: begin
				req.we    = 1'b1;
				req.waddr = j_q;
				req.wdata = t_q;
			end
			ST_C0: add_a = crush_lo;
			ST_C1: add_a = crush_hi;
			ST_C2: begin
				req.we    = (t_q > rdata);
				req.waddr = crush_lo;
				req.wdata = rdata;
			end
			ST_C3: begin
				req.we    = 1'b1;
				req.waddr = crush_hi;
				req.wdata = t_q;
			end
			ST_N0: add_a = a_q;
			ST_N1: add_a = nib_addr;
			ST_N2: begin
				req.we    = 1'b1;
				req.waddr = a_q;
				req.wdata = rdata;
			end
			ST_N3: begin
				req.we    = 1'b1;
				req.waddr = nib_addr;
				req.wdata = t_q;
			end
			ST_O0: begin
				add_a = z_q;
				add_b = k_q;
			end
			ST_O1: begin
				add_a = i_q;
				add_b = rdata;
			end
			ST_O2: begin
				add_a = j_q;
				add_b = rdata;
			end
			default: ;
		endcase
		req.raddr = add_sum;
	end

	// Sequencer: state, sponge registers and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_INIT;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			z_q         <= '0;
			a_q         <= '0;
			w_q         <= IDX_W'(1);
			t_q         <= '0;
			byte_q      <= '0;
			nib_hi_q    <= 1'b0;
			shuf_q      <= 1'b0;
			phase_q     <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			stream_q    <= '0;
		end else begin
			if (out_valid_q && out_ready && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q     <= op_in;
						byte_q   <= data_byte;
						nib_hi_q <= 1'b0;
						phase_q  <= '0;
						cnt_q    <= '0;
						case (op_in)
							OP_INIT: begin
								i_q <= '0;
								j_q <= '0;
								k_q <= '0;
								z_q <= '0;
								a_q <= '0;
								w_q <= IDX_W'(1);
							end
							OP_ABSORB: begin
								if (a_q == IDX_W'(HALF_SIZE)) begin
									shuf_q  <= 1'b1;
									state_q <= ST_U0;
								end else begin
									state_q <= ST_N0;
								end
							end
							OP_STOP: begin
								if (a_q == IDX_W'(HALF_SIZE)) begin
									shuf_q  <= 1'b1;
									state_q <= ST_U0;
								end else begin
									a_q <= a_q + IDX_W'(1);
								end
							end
							default: begin
								shuf_q  <= (a_q != '0);
								state_q <= ST_U0;
							end
						endcase
					end
				end
				// One update of i, j, k and the swap
				ST_U0: begin
					i_q     <= add_sum;
					state_q <= ST_U1;
				end
				ST_U1: begin
					t_q     <= rdata;
					state_q <= ST_U2;
				end
				ST_U2: begin
					j_q     <= add_sum;
					state_q <= ST_U3;
				end
				ST_U3: begin
					k_q     <= i_q + k_q + rdata;
					state_q <= ST_U4;
				end
				ST_U4: begin
					if (!shuf_q) begin
						state_q <= ST_O0;
					end else if (cnt_q == CNT_W'(WHIP_N - 1)) begin
						w_q   <= w_q + IDX_W'(2);
						cnt_q <= '0;
						if (phase_q == PH_W'(PH_LAST)) begin
							// Shuffle done: resume the held operation
							shuf_q <= 1'b0;
							case (op_q)
								OP_ABSORB: begin
									a_q     <= '0;
									state_q <= ST_N0;
								end
								OP_STOP: begin
									a_q     <= IDX_W'(1);
									state_q <= ST_IDLE;
								end
								default: begin
									a_q     <= '0;
									state_q <= ST_U0;
								end
							endcase
						end else begin
							phase_q <= phase_q + PH_W'(1);
							state_q <= ST_C0;
						end
					end else begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= ST_U0;
					end
				end
				// Crush: order each mirrored pair
				ST_C0: state_q <= ST_C1;
				ST_C1: begin
					t_q     <= rdata;
					state_q <= ST_C2;
				end
				ST_C2, ST_C3: begin
					if ((state_q == ST_C2) && (t_q > rdata)) begin
						state_q <= ST_C3;
					end else if (crush_v == HALF_W'(HALF_SIZE - 1)) begin
						cnt_q   <= '0;
						phase_q <= phase_q + PH_W'(1);
						state_q <= ST_U0;
					end else begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= ST_C0;
					end
				end
				// Absorb one nibble into the upper half
				ST_N0: state_q <= ST_N1;
				ST_N1: begin
					t_q     <= rdata;
					state_q <= ST_N2;
				end
				ST_N2: state_q <= ST_N3;
				ST_N3: begin
					a_q <= a_q + IDX_W'(1);
					if (nib_hi_q) begin
						state_q <= ST_IDLE;
					end else begin
						nib_hi_q <= 1'b1;
						if (a_q == IDX_W'(HALF_SIZE - 1)) begin
							shuf_q  <= 1'b1;
							state_q <= ST_U0;
						end else begin
							state_q <= ST_N0;
						end
					end
				end
				// Output chain of three dependent reads
				ST_O0: state_q <= ST_O1;
				ST_O1: state_q <= ST_O2;
				ST_O2: state_q <= ST_O3;
				ST_O3: begin
					z_q     <= rdata;
					state_q <= ST_OUT;
				end
				// Hold the byte until the output register is free
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						stream_q    <= z_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The absorb count never passes half the state
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		a_q <= IDX_W'(HALF_SIZE))
		else $error("absorb count above half state");

	// Stride stays odd across whips
	w_odd: assert property (@(posedge clk) disable iff (!arst_n)
		w_q[0])
		else $error("stride lost its odd value");

	// No shuffle is pending once the block takes items
	idle_no_shuffle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !shuf_q)
		else $error("shuffle flag left set in idle");

	// A result appears only after the output chain
	out_from_chain: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result raised outside the output step");

	// The store is cleared only from idle and never written there
	idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !req.we)
		else $error("permutation written in idle");

endmodule

>>> bench/spritz_sponge_engine_core_tb.sv
`timescale 1ns / 1ps

module spritz_sponge_engine_core_tb;
	import sse_pkg::*;

	localparam int CYCLE_LIMIT = 5_000_000;
	localparam int RANDOM_ITEMS = 1400;
	localparam int MAX_PRINTED = 20;

	typedef struct {
		op_t        op;
		logic [7:0] data;
		bit         drain;
	} sponge_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	op_t        operation = OP_INIT;
	logic [7:0] data_byte = 8'h00;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] stream_byte;

	sponge_item_t pending_items[$];
	logic [7:0]   drip_bytes[$];
	int           drips_sent = 0;
	int           drips_seen = 0;
	int           items_done = 0;
	int           n_items = 0;
	int           n_directed = 0;
	int           n_errors = 0;
	int           n_drains = 0;
	int           n_shuffles = 0;
	int           n_half_shuffles = 0;
	int           cycles = 0;

	// Idle pacing on each side
	int tx_gap = 0;
	int tx_left = 0;
	bit tx_calm = 1'b0;
	int rx_stall = 0;
	int rx_left = 0;
	bit rx_calm = 1'b0;

	// Predicted sponge state
	logic [7:0] sbox [STATE_SIZE];
	logic [7:0] ri, rj, rk, rz, ra, rw;

	spritz_sponge_engine_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.operation  (operation),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.stream_byte(stream_byte)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Sponge predictor
	function automatic void sbox_swap(logic [7:0] x, logic [7:0] y);
		logic [7:0] t;
		t = sbox[x];
		sbox[x] = sbox[y];
		sbox[y] = t;
	endfunction

	function automatic void sponge_clear();
		for (int n = 0; n < STATE_SIZE; n++)
			sbox[n] = 8'(n);
		ri = 8'h00;
		rj = 8'h00;
		rk = 8'h00;
		rz = 8'h00;
		ra = 8'h00;
		rw = 8'h01;
	endfunction

	function automatic void sponge_update();
		logic [7:0] t;
		ri = ri + rw;
		t = rj + sbox[ri];
		rj = rk + sbox[t];
		rk = ri + rk + sbox[rj];
		sbox_swap(ri, rj);
	endfunction

	function automatic logic [7:0] sponge_out();
		logic [7:0] t;
		t = rz + rk;
		t = sbox[t];
		t = ri + t;
		t = sbox[t];
		t = rj + t;
		rz = sbox[t];
		return rz;
	endfunction

	function automatic void sponge_whip();
		for (int n = 0; n < WHIP_N; n++)
			sponge_update();
		rw = rw + 8'd2;
	endfunction

	function automatic void sponge_crush();
		logic [7:0] lo, hi;
		for (int v = 0; v < HALF_SIZE; v++) begin
			lo = 8'(v);
			hi = 8'(STATE_SIZE - 1 - v);
			if (sbox[lo] > sbox[hi])
				sbox_swap(lo, hi);
		end
	endfunction

	function automatic void sponge_shuffle();
		sponge_whip();
		sponge_crush();
		sponge_whip();
		sponge_crush();
		sponge_whip();
		ra = 8'h00;
		n_shuffles++;
	endfunction

	function automatic void sponge_nibble(logic [3:0] x);
		logic [7:0] slot;
		if (ra == 8'(HALF_SIZE)) begin
			sponge_shuffle();
			n_half_shuffles++;
		end
		slot = 8'(HALF_SIZE) | {4'h0, x};
		sbox_swap(ra, slot);
		ra = ra + 8'd1;
	endfunction

	// Advance the predicted state by one item; true when a stream byte is due
	function automatic bit sponge_step(op_t op, logic [7:0] d, output logic [7:0] q);
		q = 8'h00;
		case (op)
			OP_INIT: begin
				sponge_clear();
			end
			OP_ABSORB: begin
				sponge_nibble(d[3:0]);
				sponge_nibble(d[7:4]);
			end
			OP_STOP: begin
				if (ra == 8'(HALF_SIZE)) begin
					sponge_shuffle();
					n_half_shuffles++;
				end
				ra = ra + 8'd1;
			end
			default: begin
				if (ra != 8'h00)
					sponge_shuffle();
				sponge_update();
				q = sponge_out();
				return 1'b1;
			end
		endcase
		return 1'b0;
	endfunction

	// Idle length per item, in stretches of busy or calm pacing
	function automatic int draw_wait(inout int left, inout bit calm);
		if (left == 0) begin
			left = $urandom_range(8, 60);
			calm = ($urandom_range(0, 2) == 0);
		end
		left--;
		return calm ? 0 : $urandom_range(0, 12);
	endfunction

	function automatic void queue_item(op_t op, logic [7:0] d);
		sponge_item_t it;
		it.op = op;
		it.data = d;
		it.drain = 1'b0;
		pending_items.push_back(it);
	endfunction

	task automatic report_mismatch(string what);
		if (n_errors < MAX_PRINTED)
			$display("[%0t] MISMATCH: %s", $realtime, what);
		n_errors++;
	endtask

	// Drive items, predict each one as it is accepted
	always @(posedge clk) begin : p_drive
		logic [7:0] drip_q;
		bit         fired;
		bit         gives_byte;
		int         owed;
		if (arst_n) begin
			fired = in_valid && in_ready;
			gives_byte = 1'b0;
			if (fired) begin
				gives_byte = sponge_step(operation, data_byte, drip_q);
				if (gives_byte)
					drip_bytes.push_back(drip_q);
				items_done <= items_done + 1;
				tx_gap = draw_wait(tx_left, tx_calm);
			end else if (!in_valid && tx_gap > 0) begin
				tx_gap--;
			end
			if (gives_byte)
				drips_sent <= drips_sent + 1;
			owed = drips_sent + (gives_byte ? 1 : 0) - drips_seen;
			if ((fired || !in_valid) && tx_gap == 0 && pending_items.size() > 0 &&
			    (!pending_items[0].drain || owed == 0)) begin
				in_valid <= 1'b1;
				operation <= pending_items[0].op;
				data_byte <= pending_items[0].data;
				if (pending_items[0].drain)
					n_drains++;
				pending_items.delete(0);
			end else if (fired) begin
				in_valid <= 1'b0;
			end
		end
	end

	// Collect stream bytes and compare against the oldest outstanding drip
	always @(posedge clk) begin : p_collect
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (drips_seen >= drips_sent) begin
					report_mismatch($sformatf("stream byte %02h with no drip outstanding",
						stream_byte));
				end else begin
					if (stream_byte !== drip_bytes[drips_seen])
						report_mismatch($sformatf("drip %0d: stream_byte %02h, want %02h",
							drips_seen, stream_byte, drip_bytes[drips_seen]));
					drips_seen <= drips_seen + 1;
				end
				rx_stall = draw_wait(rx_left, rx_calm);
			end else if (rx_stall > 0) begin
				rx_stall--;
			end
			out_ready <= (rx_stall == 0);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles: %0d of %0d items, %0d of %0d bytes",
				cycles, items_done, n_items, drips_seen, drips_sent);
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		int         seq_no;
		int         first;
		int         nb;
		int         nd;
		bit         long_seq;
		bit         hold;
		sponge_clear();

		// Directed: fresh drips, ignored data, both byte extremes, re-initialise
		queue_item(OP_DRIP, 8'hff);
		queue_item(OP_DRIP, 8'h00);
		queue_item(OP_STOP, 8'hff);
		queue_item(OP_ABSORB, 8'h00);
		queue_item(OP_ABSORB, 8'hff);
		queue_item(OP_ABSORB, 8'ha5);
		queue_item(OP_ABSORB, 8'h5a);
		queue_item(OP_DRIP, 8'h3c);
		queue_item(OP_DRIP, 8'hc3);
		queue_item(OP_INIT, 8'hff);
		pending_items[pending_items.size() - 1].drain = 1'b1;
		queue_item(OP_DRIP, 8'h81);
		queue_item(OP_ABSORB, 8'h0f);
		queue_item(OP_ABSORB, 8'hf0);
		queue_item(OP_STOP, 8'h00);
		queue_item(OP_DRIP, 8'h7e);
		queue_item(OP_DRIP, 8'h00);
		queue_item(OP_INIT, 8'h00);
		queue_item(OP_STOP, 8'h55);
		queue_item(OP_DRIP, 8'haa);
		n_directed = pending_items.size();

		// Random: absorb phases followed by drip runs, with some noise
		seq_no = 0;
		while (pending_items.size() < n_directed + RANDOM_ITEMS) begin
			first = pending_items.size();
			long_seq = (seq_no < 2) || ($urandom_range(0, 24) == 0);
			hold = (seq_no < 2) || ($urandom_range(0, 9) == 0);
			if (long_seq || $urandom_range(0, 2) == 0)
				queue_item(OP_INIT, 8'($urandom_range(0, 255)));
			if (long_seq) begin
				// fill to half the state, then hit the boundary with a stop or a nibble
				for (int k = 0; k < HALF_SIZE / 2; k++)
					queue_item(OP_ABSORB, 8'($urandom_range(0, 255)));
				if (seq_no == 0 || (seq_no != 1 && $urandom_range(0, 1) == 0))
					queue_item(OP_STOP, 8'($urandom_range(0, 255)));
				else
					queue_item(OP_ABSORB, 8'($urandom_range(0, 255)));
				nb = $urandom_range(0, 3);
			end else begin
				nb = $urandom_range(0, 6);
			end
			for (int k = 0; k < nb; k++) begin
				if ($urandom_range(0, 3) == 0)
					queue_item(OP_STOP, 8'($urandom_range(0, 255)));
				else
					queue_item(OP_ABSORB, 8'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 4) == 0) begin
				nb = $urandom_range(1, 3);
				for (int k = 0; k < nb; k++)
					queue_item(op_t'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
			end
			nd = $urandom_range(1, 30);
			for (int k = 0; k < nd; k++)
				queue_item(OP_DRIP, 8'($urandom_range(0, 255)));
			if (hold)
				pending_items[first].drain = 1'b1;
			seq_no++;
		end
		n_items = pending_items.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (items_done != n_items || drips_seen != drips_sent)
			@(posedge clk);
		repeat (64) @(posedge clk);

		$display("%0d items (%0d directed, %0d drain pauses), %0d stream bytes checked",
			n_items, n_directed, n_drains, drips_seen);
		$display("%0d shuffles predicted, %0d of them at a half-state absorb count",
			n_shuffles, n_half_shuffles);
		if (n_errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches counted", n_errors);
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/sse_pkg.sv
rtl/sse_perm.sv
rtl/spritz_sponge_engine_core.sv
bench/spritz_sponge_engine_core_tb.sv
